// ===== rtl/slab_bitmap_cell_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the slab bitmap cell allocator
// Shared helpers that wrap a concurrent assertion clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLAB_BITMAP_CELL_ALLOCATOR_UNIT_DEFINES_SVH
`define SLAB_BITMAP_CELL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define SBCA_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SBCA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sbca_pkg.sv =====
// ----------------------------------------------------------------------------
// sbca_pkg
// Shared types and constants of the slab bitmap cell allocator.
// ----------------------------------------------------------------------------
package sbca_pkg;

   // Default sizing
   localparam int NUM_CLASSES_DEF  = 4;
   localparam int MAX_SEGMENTS_DEF = 16;

   // Fixed geometry
   localparam int SIZE_REGS      = 4;
   localparam int WORD_W         = 64;
   localparam int BIT_W          = 6;
   localparam int SIZE_W         = 16;
   localparam int CLS_CNT_W      = 3;
   localparam int SEG_CNT_W      = 5;
   localparam int CSR_INDEX_W    = 3;
   localparam int STATUS_W       = 2;
   localparam int CLASS_W        = 2;
   localparam int CELL_W         = 10;
   localparam int OFFSET_W       = 26;

   localparam logic [WORD_W-1:0] FULL_SEGMENT = {WORD_W{1'b1}};

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_SIZE_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_SIZE_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_SIZE_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_SIZE_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASSES_IN_USE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENTS       = 3'd5;

   // Register reset values
   localparam logic [SIZE_W-1:0]    RST_CLASS_SIZE_0   = 16'd16;
   localparam logic [SIZE_W-1:0]    RST_CLASS_SIZE_1   = 16'd64;
   localparam logic [SIZE_W-1:0]    RST_CLASS_SIZE_2   = 16'd256;
   localparam logic [SIZE_W-1:0]    RST_CLASS_SIZE_3   = 16'd1024;
   localparam logic [CLS_CNT_W-1:0] RST_CLASSES_IN_USE = 3'd4;
   localparam logic [SEG_CNT_W-1:0] RST_SEGMENTS       = 5'd16;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SELECT,
      ST_FETCH,
      ST_CHECK,
      ST_MULT,
      ST_EMIT
   } state_type;

   // Segment scan result
   typedef struct packed {
      logic              full;
      logic [BIT_W-1:0]  bit_idx;
      logic [WORD_W-1:0] marked;
   } scan_result_type;

endpackage

// ===== rtl/sbca_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// sbca_bitmap_mem
// Occupancy bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbca_bitmap_mem #(
   parameter int DEPTH  = sbca_pkg::NUM_CLASSES_DEF * sbca_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [sbca_pkg::WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [sbca_pkg::WORD_W-1:0] rd_data
);

   logic [sbca_pkg::WORD_W-1:0] mem [DEPTH];
   logic [sbca_pkg::WORD_W-1:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sbca_seg_scan.sv =====
// ----------------------------------------------------------------------------
// sbca_seg_scan
// Segment test unit: flags a full segment, finds its lowest clear bit and
// forms the word with that bit set.
// ----------------------------------------------------------------------------
module sbca_seg_scan (
   input  logic [sbca_pkg::WORD_W-1:0] word,
   output sbca_pkg::scan_result_type   result
);

   logic [sbca_pkg::BIT_W-1:0] bit_idx;

   // Lowest clear bit, scanning from the top so the lowest wins
   always_comb begin
      bit_idx = '0;
      for (int i = sbca_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            bit_idx = sbca_pkg::BIT_W'(i);
         end
      end
   end

   // Pack the result
   always_comb begin
      result.full    = (word == sbca_pkg::FULL_SEGMENT);
      result.bit_idx = bit_idx;
      result.marked  = word | (sbca_pkg::WORD_W'(1) << bit_idx);
   end

endmodule

// ===== rtl/slab_bitmap_cell_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// slab_bitmap_cell_allocator_unit
// First-fit slab cell allocator over per-class 64-bit occupancy bitmaps.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the bitmap memory once to mark every cell free,
// one word per cycle, NUM_CLASSES*MAX_SEGMENTS words (64 by default); requests
// stall during the sweep while CSR writes are taken. A request then runs on a
// small sequencer: select compares the size classes one at a time and takes
// the first class whose size is at least the request, fetch reads the first
// bitmap segment, check tests one segment at a time in the shared segment
// scan unit, mult forms the byte offset and emit posts the result once the
// result register is free. With no fitting class, no segment in use or every
// segment full, the request goes on to emit with no cell. The time a request
// takes is set mostly by how many full segments precede a free cell. Only one
// request is in flight at a time; the next one is accepted while the previous
// result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`include "slab_bitmap_cell_allocator_unit_defines.svh"

module slab_bitmap_cell_allocator_unit #(
   parameter int NUM_CLASSES  = sbca_pkg::NUM_CLASSES_DEF,
   parameter int MAX_SEGMENTS = sbca_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sbca_pkg::SIZE_W-1:0]         req_request_size,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbca_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sbca_pkg::CLASS_W-1:0]        rsp_class_index,
   output logic [sbca_pkg::CELL_W-1:0]         rsp_cell_index,
   output logic [sbca_pkg::OFFSET_W-1:0]       rsp_byte_offset,
   // CSR write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sbca_pkg::SIZE_W-1:0]         csr_wdata
);

   localparam int DEPTH   = NUM_CLASSES * MAX_SEGMENTS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CELLX_W = SEG_W + sbca_pkg::BIT_W;
   localparam int PROD_W  = CELLX_W + sbca_pkg::SIZE_W;
   localparam int CLS_CAP = (NUM_CLASSES < sbca_pkg::SIZE_REGS) ? NUM_CLASSES
                                                                 : sbca_pkg::SIZE_REGS;
   localparam int CNT_W   = 7;

   // Configuration registers
   logic [sbca_pkg::SIZE_W-1:0]    class_size_ff [sbca_pkg::SIZE_REGS];
   logic [sbca_pkg::SIZE_W-1:0]    class_size_in [sbca_pkg::SIZE_REGS];
   logic [sbca_pkg::CLS_CNT_W-1:0] classes_ff, classes_in;
   logic [sbca_pkg::SEG_CNT_W-1:0] segments_ff, segments_in;

   // Sequencer and work registers
   sbca_pkg::state_type            state_ff, state_in;
   logic [ADDR_W-1:0]              clr_addr_ff, clr_addr_in;
   logic [sbca_pkg::SIZE_W-1:0]    req_size_ff, req_size_in;
   logic [sbca_pkg::CLS_CNT_W-1:0] cls_ff, cls_in;
   logic [SEG_W-1:0]               seg_ff, seg_in;
   logic [sbca_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [CELLX_W-1:0]             cell_ff, cell_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;

   // Result registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sbca_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [sbca_pkg::CLASS_W-1:0]   rsp_class_ff, rsp_class_in;
   logic [sbca_pkg::CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [sbca_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;

   // Combinational helpers
   logic [sbca_pkg::CLS_CNT_W-1:0] limit;
   logic [sbca_pkg::SEG_CNT_W-1:0] segs;
   logic [sbca_pkg::SIZE_W-1:0]    cur_size;
   logic                           size_fits;
   logic [CNT_W-1:0]               seg_next;
   logic                           last_seg;
   logic                           slot_free;
   logic [SEG_W-1:0]               rd_seg;
   logic [ADDR_W-1:0]              rd_addr;
   logic [ADDR_W-1:0]              cur_addr;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [sbca_pkg::WORD_W-1:0]    wr_data;
   logic [sbca_pkg::WORD_W-1:0]    rd_word;
   sbca_pkg::scan_result_type      scan;

   // Saturate class and segment counts
   always_comb begin
      limit = (classes_ff > sbca_pkg::CLS_CNT_W'(CLS_CAP))
              ? sbca_pkg::CLS_CNT_W'(CLS_CAP) : classes_ff;
      segs  = (CNT_W'(segments_ff) > CNT_W'(MAX_SEGMENTS))
              ? sbca_pkg::SEG_CNT_W'(MAX_SEGMENTS) : segments_ff;
   end

   // Shared compare and segment bookkeeping
   always_comb begin
      cur_size  = class_size_ff[cls_ff[sbca_pkg::CLASS_W-1:0]];
      size_fits = (cur_size >= req_size_ff);
      seg_next  = CNT_W'(seg_ff) + CNT_W'(1);
      last_seg  = (seg_next >= CNT_W'(segs));
      slot_free = !rsp_valid_ff || !rsp_stall;
   end

   // Bitmap addressing
   always_comb begin
      rd_seg   = (state_ff == sbca_pkg::ST_CHECK && scan.full && !last_seg)
                 ? SEG_W'(seg_next) : seg_ff;
      rd_addr  = ADDR_W'(int'(cls_ff) * MAX_SEGMENTS + int'(rd_seg));
      cur_addr = ADDR_W'(int'(cls_ff) * MAX_SEGMENTS + int'(seg_ff));
   end

   sbca_bitmap_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   sbca_seg_scan u_scan (
      .word   (rd_word),
      .result (scan)
   );

   // CSR writes
   always_comb begin
      for (int i = 0; i < sbca_pkg::SIZE_REGS; i++) begin
         class_size_in[i] = class_size_ff[i];
      end
      classes_in  = classes_ff;
      segments_in = segments_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sbca_pkg::REG_CLASS_SIZE_0:   class_size_in[0] = csr_wdata;
            sbca_pkg::REG_CLASS_SIZE_1:   class_size_in[1] = csr_wdata;
            sbca_pkg::REG_CLASS_SIZE_2:   class_size_in[2] = csr_wdata;
            sbca_pkg::REG_CLASS_SIZE_3:   class_size_in[3] = csr_wdata;
            sbca_pkg::REG_CLASSES_IN_USE: classes_in = csr_wdata[sbca_pkg::CLS_CNT_W-1:0];
            sbca_pkg::REG_SEGMENTS:       segments_in = csr_wdata[sbca_pkg::SEG_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_size_ff[0] <= sbca_pkg::RST_CLASS_SIZE_0;
         class_size_ff[1] <= sbca_pkg::RST_CLASS_SIZE_1;
         class_size_ff[2] <= sbca_pkg::RST_CLASS_SIZE_2;
         class_size_ff[3] <= sbca_pkg::RST_CLASS_SIZE_3;
         classes_ff       <= sbca_pkg::RST_CLASSES_IN_USE;
         segments_ff      <= sbca_pkg::RST_SEGMENTS;
      end else begin
         class_size_ff <= class_size_in;
         classes_ff    <= classes_in;
         segments_ff   <= segments_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbca_pkg::ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = sbca_pkg::ST_IDLE;
            end
         end
         sbca_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sbca_pkg::ST_SELECT;
            end
         end
         sbca_pkg::ST_SELECT: begin
            priority if (cls_ff >= limit) begin
               state_in = sbca_pkg::ST_EMIT;
            end else if (size_fits && segs == '0) begin
               state_in = sbca_pkg::ST_EMIT;
            end else if (size_fits) begin
               state_in = sbca_pkg::ST_FETCH;
            end else begin
               state_in = sbca_pkg::ST_SELECT;
            end
         end
         sbca_pkg::ST_FETCH: state_in = sbca_pkg::ST_CHECK;
         sbca_pkg::ST_CHECK: begin
            priority if (!scan.full) begin
               state_in = sbca_pkg::ST_MULT;
            end else if (last_seg) begin
               state_in = sbca_pkg::ST_EMIT;
            end else begin
               state_in = sbca_pkg::ST_CHECK;
            end
         end
         sbca_pkg::ST_MULT: state_in = sbca_pkg::ST_EMIT;
         sbca_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = sbca_pkg::ST_IDLE;
            end
         end
         default: state_in = sbca_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs and work register updates
   always_comb begin
      req_stall   = (state_ff != sbca_pkg::ST_IDLE);
      csr_ready   = 1'b1;
      clr_addr_in = clr_addr_ff;
      req_size_in = req_size_ff;
      cls_in      = cls_ff;
      seg_in      = seg_ff;
      status_in   = status_ff;
      cell_in     = cell_ff;
      prod_in     = prod_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_addr;
      wr_data     = scan.marked;
      unique case (state_ff)
         sbca_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         sbca_pkg::ST_IDLE: begin
            req_size_in = req_request_size;
            cls_in      = '0;
            seg_in      = '0;
            status_in   = sbca_pkg::STATUS_NOFIT;
         end
         sbca_pkg::ST_SELECT: begin
            if (cls_ff < limit) begin
               if (size_fits) begin
                  status_in = sbca_pkg::STATUS_FULL;
               end else begin
                  cls_in = cls_ff + sbca_pkg::CLS_CNT_W'(1);
               end
            end
         end
         sbca_pkg::ST_FETCH: ;
         sbca_pkg::ST_CHECK: begin
            if (!scan.full) begin
               wr_en     = 1'b1;
               status_in = sbca_pkg::STATUS_ALLOC;
               cell_in   = {seg_ff, scan.bit_idx};
            end else if (!last_seg) begin
               seg_in = SEG_W'(seg_next);
            end
         end
         sbca_pkg::ST_MULT: begin
            prod_in = PROD_W'(cell_ff) * PROD_W'(cur_size);
         end
         sbca_pkg::ST_EMIT: ;
         default: ;
      endcase
   end

   // Result register: load on emit, drop on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_offset_in = rsp_offset_ff;
      if (state_ff == sbca_pkg::ST_EMIT && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_class_in  = (status_ff == sbca_pkg::STATUS_NOFIT)
                         ? '0 : cls_ff[sbca_pkg::CLASS_W-1:0];
         rsp_cell_in   = (status_ff == sbca_pkg::STATUS_ALLOC)
                         ? sbca_pkg::CELL_W'(cell_ff) : '0;
         rsp_offset_in = (status_ff == sbca_pkg::STATUS_ALLOC)
                         ? sbca_pkg::OFFSET_W'(prod_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbca_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff   <= req_size_in;
      cls_ff        <= cls_in;
      seg_ff        <= seg_in;
      status_ff     <= status_in;
      cell_ff       <= cell_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_class_index = rsp_class_ff;
   assign rsp_cell_index  = rsp_cell_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   // Checks
   `SBCA_ASSERT_IMPLY(a_fail_no_cell,
      rsp_valid && rsp_status != sbca_pkg::STATUS_ALLOC,
      rsp_cell_index == '0 && rsp_byte_offset == '0,
      "failed allocation carries a cell or offset")
   `SBCA_ASSERT_IMPLY(a_mark_only_free,
      wr_en && state_ff == sbca_pkg::ST_CHECK,
      !scan.full && $countones(scan.marked) == $countones(rd_word) + 1,
      "bitmap write does not set exactly one free cell")
   `SBCA_ASSERT_NEXT(a_result_from_emit,
      state_ff != sbca_pkg::ST_EMIT && !(rsp_valid && rsp_stall),
      !rsp_valid,
      "result posted without passing through emit")

endmodule

// ===== tb/sv/slab_alloc_check_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab allocator check package
// Grant record and the tracker that mirrors the allocator: it holds its own
// copy of the size registers and the occupancy bitmaps, works out the grant
// for every request handed to the unit and checks each grant that comes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slab_alloc_check_pkg;

   import sbca_pkg::*;

   // One result transfer, in port order
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  class_index;
      logic [CELL_W-1:0]   cell_index;
      logic [OFFSET_W-1:0] byte_offset;
   } allocation_grant_t;

   class cell_allocation_tracker;
      logic [WORD_W-1:0]    occupancy [NUM_CLASSES_DEF*MAX_SEGMENTS_DEF];
      logic [SIZE_W-1:0]    cell_size [SIZE_REGS];
      logic [CLS_CNT_W-1:0] class_count;
      logic [SEG_CNT_W-1:0] segment_count;
      allocation_grant_t    expected_grants [$];
      int                   errors;
      int                   granted;
      int                   no_fit;
      int                   arena_full;
      int                   deepest_cell;

      // Start from the reset state: every cell free, default classes
      function new();
         foreach (occupancy[i]) occupancy[i] = '0;
         cell_size[0]  = RST_CLASS_SIZE_0;
         cell_size[1]  = RST_CLASS_SIZE_1;
         cell_size[2]  = RST_CLASS_SIZE_2;
         cell_size[3]  = RST_CLASS_SIZE_3;
         class_count   = RST_CLASSES_IN_USE;
         segment_count = RST_SEGMENTS;
         errors        = 0;
         granted       = 0;
         no_fit        = 0;
         arena_full    = 0;
         deepest_cell  = 0;
      endfunction

      // Mirror a register write; upper data bits drop, unknown indexes do nothing
      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [SIZE_W-1:0] data);
         case (idx)
            REG_CLASS_SIZE_0:   cell_size[0] = data;
            REG_CLASS_SIZE_1:   cell_size[1] = data;
            REG_CLASS_SIZE_2:   cell_size[2] = data;
            REG_CLASS_SIZE_3:   cell_size[3] = data;
            REG_CLASSES_IN_USE: class_count = data[CLS_CNT_W-1:0];
            REG_SEGMENTS:       segment_count = data[SEG_CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Allocate for an accepted request and queue the grant it must produce
      function void note_request(input logic [SIZE_W-1:0] size);
         allocation_grant_t grant;
         logic [WORD_W-1:0] word;
         longint unsigned   offset;
         int                limit;
         int                segs;
         int                cls;
         int                free_bit;
         int                cell_no;
         limit = int'(class_count);
         if (limit > NUM_CLASSES_DEF) limit = NUM_CLASSES_DEF;
         if (limit > SIZE_REGS) limit = SIZE_REGS;
         segs = int'(segment_count);
         if (segs > MAX_SEGMENTS_DEF) segs = MAX_SEGMENTS_DEF;
         grant = '0;
         grant.status = STATUS_NOFIT;
         // Walk down so the lowest fitting class wins, in register order
         cls = -1;
         for (int c = limit - 1; c >= 0; c--) begin
            if (cell_size[c] >= size) cls = c;
         end
         if (cls < 0) begin
            no_fit++;
         end else begin
            grant.status      = STATUS_FULL;
            grant.class_index = cls[CLASS_W-1:0];
            // Skip full segments, take the lowest clear bit of the first open one
            for (int s = 0; s < segs && grant.status == STATUS_FULL; s++) begin
               word = occupancy[cls*MAX_SEGMENTS_DEF + s];
               if (word != FULL_SEGMENT) begin
                  free_bit = 0;
                  while (word[free_bit]) free_bit++;
                  occupancy[cls*MAX_SEGMENTS_DEF + s][free_bit] = 1'b1;
                  cell_no = s*WORD_W + free_bit;
                  offset  = 64'(cell_no) * 64'(cell_size[cls]);
                  grant.status      = STATUS_ALLOC;
                  grant.cell_index  = cell_no[CELL_W-1:0];
                  grant.byte_offset = offset[OFFSET_W-1:0];
                  if (cell_no > deepest_cell) deepest_cell = cell_no;
               end
            end
            if (grant.status == STATUS_ALLOC) granted++;
            else arena_full++;
         end
         expected_grants.push_back(grant);
      endfunction

      function void compare_field(input string name, input longint want,
                                  input longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Check a result transfer against the oldest queued grant
      function void check_grant(input allocation_grant_t got);
         allocation_grant_t want;
         if (expected_grants.size() == 0) begin
            $display("%0t: result with no request pending, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_grants.pop_front();
         if ($isunknown(got)) begin
            $display("%0t: unknown bits in result, expected %h, actual %h", $time, want, got);
            errors++;
            return;
         end
         compare_field("status", longint'(want.status), longint'(got.status));
         compare_field("class_index", longint'(want.class_index),
                       longint'(got.class_index));
         compare_field("cell_index", longint'(want.cell_index), longint'(got.cell_index));
         compare_field("byte_offset", longint'(want.byte_offset),
                       longint'(got.byte_offset));
      endfunction

      function int outstanding();
         return expected_grants.size();
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_slab_bitmap_cell_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Slab bitmap cell allocator testbench
// Directed requests at class boundaries and register extremes, then random
// phases under varying class and segment setups, with bursty requests and a
// randomly stalling result side. Every grant is checked against a tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slab_bitmap_cell_allocator_unit;

   import sbca_pkg::*;
   import slab_alloc_check_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;
   localparam int RANDOM_REQUESTS = 1700;
   localparam int DRAIN_CYCLES    = 40;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [SIZE_W-1:0]      req_request_size = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [CLASS_W-1:0]     rsp_class_index;
   logic [CELL_W-1:0]      rsp_cell_index;
   logic [OFFSET_W-1:0]    rsp_byte_offset;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [SIZE_W-1:0]      csr_wdata        = '0;

   cell_allocation_tracker tracker = new();

   int requests_sent = 0;
   int csr_writes    = 0;
   int phases        = 0;
   int burst_left    = 0;
   bit req_up        = 1'b0;
   int stall_left    = 0;
   int stall_mode    = 0;

   slab_bitmap_cell_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_class_index  (rsp_class_index),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_byte_offset  (rsp_byte_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // Stall the result side: free runs, light and heavy random, solid blocks
   always @(posedge clock) begin
      if (!reset) begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 10) : $urandom_range(1, 60);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_grant({rsp_status, rsp_class_index, rsp_cell_index, rsp_byte_offset});
   end

   // Present one request, hold it until the transfer, then maybe open a gap
   task automatic issue_request(input logic [SIZE_W-1:0] size);
      int gap;
      req_valid        <= 1'b1;
      req_request_size <= size;
      req_up = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(size);
      requests_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7))
            0, 1, 2, 3: gap = 0;
            4, 5:       gap = $urandom_range(1, 3);
            6:          gap = $urandom_range(4, 12);
            default:    gap = $urandom_range(13, 30);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Drop the request line and wait until every queued grant has arrived
   task automatic wait_idle();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_valid after its last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, data);
      csr_writes++;
   endtask

   // Load a random class setup; a segment count of -1 picks one at random
   task automatic load_random_setup(input int seg_override);
      logic [SIZE_W-1:0] sizes [SIZE_REGS];
      logic [SIZE_W-1:0] swap;
      int                mode;
      int                count;
      int                segs;
      mode = $urandom_range(0, 3);
      foreach (sizes[i]) begin
         case (mode)
            0: sizes[i] = 16'($urandom_range(1, 4096));
            1: sizes[i] = 16'($urandom_range(1, 300));
            2: sizes[i] = 16'($urandom());
            default: begin
               case ($urandom_range(0, 3))
                  0: sizes[i] = '0;
                  1: sizes[i] = 16'd1;
                  2: sizes[i] = 16'hFFFF;
                  default: sizes[i] = 16'($urandom());
               endcase
            end
         endcase
      end
      // Sort ascending, except in the mode that tests unordered classes
      if (mode != 2) begin
         for (int j = 0; j < SIZE_REGS - 1; j++) begin
            for (int k = 0; k < SIZE_REGS - 1 - j; k++) begin
               if (sizes[k] > sizes[k+1]) begin
                  swap       = sizes[k];
                  sizes[k]   = sizes[k+1];
                  sizes[k+1] = swap;
               end
            end
         end
      end
      write_csr(REG_CLASS_SIZE_0, sizes[0]);
      write_csr(REG_CLASS_SIZE_1, sizes[1]);
      write_csr(REG_CLASS_SIZE_2, sizes[2]);
      write_csr(REG_CLASS_SIZE_3, sizes[3]);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      write_csr(REG_CLASSES_IN_USE, {13'($urandom()), count[2:0]});
      if (seg_override >= 0) segs = seg_override;
      else if ($urandom_range(0, 5) == 0) segs = $urandom_range(0, 31);
      else segs = $urandom_range(1, 16);
      write_csr(REG_SEGMENTS, {11'($urandom()), segs[4:0]});
      if ($urandom_range(0, 3) == 0)
         write_csr($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom()));
      csr_valid <= 1'b0;
   endtask

   // Mostly fitting sizes around one class, some misses and raw noise
   task automatic run_phase(input int n_items, input int focus);
      logic [SIZE_W-1:0] size;
      int                k;
      phases++;
      for (int i = 0; i < n_items; i++) begin
         k = (focus >= 0 && $urandom_range(0, 3) != 0) ? focus : $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: size = 16'($urandom());
            1: size = tracker.cell_size[k] + 16'd1;
            2: size = tracker.cell_size[k];
            3: size = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            default: size = 16'($urandom_range(0, tracker.cell_size[k]));
         endcase
         issue_request(size);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Default classes: each boundary, just past 16, 64 and 1024, and beyond the largest
      issue_request(16'd0);
      issue_request(16'd1);
      issue_request(16'd16);
      issue_request(16'd17);
      issue_request(16'd64);
      issue_request(16'd65);
      issue_request(16'd256);
      issue_request(16'd1024);
      issue_request(16'd1025);
      issue_request(16'hFFFF);

      // Zero-size class fits only an empty request; largest class takes all
      wait_idle();
      write_csr(REG_CLASS_SIZE_0, 16'd0);
      write_csr(REG_CLASS_SIZE_3, 16'hFFFF);
      csr_valid <= 1'b0;
      issue_request(16'd0);
      issue_request(16'd1);
      issue_request(16'hFFFF);

      // No classes searched: nothing fits
      wait_idle();
      write_csr(REG_CLASSES_IN_USE, 16'h0000);
      csr_valid <= 1'b0;
      issue_request(16'd0);

      // Oversized class count saturates; zero segments make every arena full
      wait_idle();
      write_csr(REG_CLASSES_IN_USE, 16'hFFFF);
      write_csr(REG_SEGMENTS, 16'h0000);
      csr_valid <= 1'b0;
      issue_request(16'd0);
      issue_request(16'd2);

      // Oversized segment count saturates; unordered sizes keep register order
      wait_idle();
      write_csr(REG_SEGMENTS, 16'hFFFF);
      write_csr(REG_CLASS_SIZE_0, 16'd1000);
      write_csr(REG_CLASS_SIZE_1, 16'd10);
      write_csr(REG_UNUSED_6, 16'hA5A5);
      write_csr(REG_UNUSED_7, 16'h5A5A);
      csr_valid <= 1'b0;
      issue_request(16'd5);
      issue_request(16'd500);
      issue_request(16'd1001);

      wait_idle();
      write_csr(REG_CLASSES_IN_USE, 16'h0005);
      write_csr(REG_SEGMENTS, 16'h0011);
      write_csr(REG_CLASS_SIZE_2, 16'd1);
      csr_valid <= 1'b0;
      issue_request(16'd1);
      phases++;

      // Deep scans: fill many segments of the smallest class
      wait_idle();
      write_csr(REG_CLASS_SIZE_0, RST_CLASS_SIZE_0);
      write_csr(REG_CLASS_SIZE_1, RST_CLASS_SIZE_1);
      write_csr(REG_CLASS_SIZE_2, RST_CLASS_SIZE_2);
      write_csr(REG_CLASS_SIZE_3, RST_CLASS_SIZE_3);
      write_csr(REG_CLASSES_IN_USE, RST_CLASSES_IN_USE);
      write_csr(REG_SEGMENTS, RST_SEGMENTS);
      csr_valid <= 1'b0;
      run_phase(500, 0);

      // One segment per arena: classes run full
      wait_idle();
      load_random_setup(1);
      run_phase(250, $urandom_range(0, 3));

      // Raise the segment count: allocation resumes past the old limit
      wait_idle();
      write_csr(REG_SEGMENTS, 16'd4);
      csr_valid <= 1'b0;
      run_phase(150, -1);

      // Random setups until the request budget is spent
      while (requests_sent < RANDOM_REQUESTS + 20) begin
         wait_idle();
         load_random_setup(-1);
         run_phase($urandom_range(60, 150),
                   ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, 3));
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d allocated, %0d with no fitting class, %0d class full",
               requests_sent, tracker.granted, tracker.no_fit, tracker.arena_full);
      $display("Deepest cell %0d, %0d register writes over %0d phases, %0d mismatches",
               tracker.deepest_cell, csr_writes, phases, tracker.errors);
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbca_pkg.sv
rtl/sbca_bitmap_mem.sv
rtl/sbca_seg_scan.sv
rtl/slab_bitmap_cell_allocator_unit.sv
tb/sv/slab_alloc_check_pkg.sv
tb/sv/tb_slab_bitmap_cell_allocator_unit.sv
